// ----- sv/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constant piece layouts for the rectangle hole cut block.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int unsigned COORD_W = 32;

    // corner selectors
    localparam logic [1:0] SEL_R0 = 2'd0;
    localparam logic [1:0] SEL_R1 = 2'd1;
    localparam logic [1:0] SEL_H0 = 2'd2;
    localparam logic [1:0] SEL_H1 = 2'd3;

    // xs/ys indexed by SEL_*
    typedef struct packed {
        logic [3:0][COORD_W-1:0] xs;
        logic [3:0][COORD_W-1:0] ys;
    } t_corners;

    // pieces per edge-flag code, code = sx | ex<<1 | sy<<2 | ey<<3
    localparam logic [3:0] PIECE_COUNT [16] = '{
        4'd8, 4'd3, 4'd3, 4'd2, 4'd3, 4'd2, 4'd2, 4'd1,
        4'd3, 4'd2, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1, 4'd0
    };

    // entry: [1:0] x0 sel, [3:2] x1 sel, [5:4] y0 sel, [7:6] y1 sel
    localparam logic [7:0] PIECE_TABLE [16][8] = '{
        '{8'h88, 8'h8E, 8'h87, 8'hE8, 8'hE7, 8'h78, 8'h7E, 8'h77},
        '{8'h84, 8'hE7, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h84, 8'hE8, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h84, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h7E, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hC7, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hC8, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h8E, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h84, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h84, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h84, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

endpackage

// ----- sv/rhc_corners.sv -----
// ----------------------------------------------------------------------------
// rhc_corners
// Input register and, for center-form requests, conversion of both rectangles to low/high corners.
// ----------------------------------------------------------------------------
module rhc_corners (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_req_type,
    input  logic signed [31:0]   i_rect_ax,
    input  logic signed [31:0]   i_rect_ay,
    input  logic signed [31:0]   i_rect_bx,
    input  logic signed [31:0]   i_rect_by,
    input  logic signed [31:0]   i_hole_ax,
    input  logic signed [31:0]   i_hole_ay,
    input  logic signed [31:0]   i_hole_bx,
    input  logic signed [31:0]   i_hole_by,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rhc_pkg::t_corners    o_corners
);
    import rhc_pkg::*;

    logic               r_vld;
    logic               r_type;
    logic [7:0][31:0]   r_raw;

    // center/size to {hi, lo}; size/2 truncates toward zero
    function automatic logic [63:0] f_center(input logic [31:0] c, input logic [31:0] s);
        logic [31:0] sum;
        logic [31:0] half;
        sum  = s + {31'b0, s[31]};
        half = {sum[31], sum[31:1]};
        return {c + s - half, c - half};
    endfunction

    logic [63:0] rx, ry, hx, hy;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_type <= i_req_type;
            r_raw  <= {i_hole_by, i_hole_bx, i_hole_ay, i_hole_ax,
                       i_rect_by, i_rect_bx, i_rect_ay, i_rect_ax};
        end
    end

    always_comb begin
        rx = f_center(r_raw[0], r_raw[2]);
        ry = f_center(r_raw[1], r_raw[3]);
        hx = f_center(r_raw[4], r_raw[6]);
        hy = f_center(r_raw[5], r_raw[7]);
        if (r_type) begin
            o_corners.xs[SEL_R0] = rx[31:0];
            o_corners.xs[SEL_R1] = rx[63:32];
            o_corners.ys[SEL_R0] = ry[31:0];
            o_corners.ys[SEL_R1] = ry[63:32];
            o_corners.xs[SEL_H0] = hx[31:0];
            o_corners.xs[SEL_H1] = hx[63:32];
            o_corners.ys[SEL_H0] = hy[31:0];
            o_corners.ys[SEL_H1] = hy[63:32];
        end else begin
            o_corners.xs[SEL_R0] = r_raw[0];
            o_corners.ys[SEL_R0] = r_raw[1];
            o_corners.xs[SEL_R1] = r_raw[2];
            o_corners.ys[SEL_R1] = r_raw[3];
            o_corners.xs[SEL_H0] = r_raw[4];
            o_corners.ys[SEL_H0] = r_raw[5];
            o_corners.xs[SEL_H1] = r_raw[6];
            o_corners.ys[SEL_H1] = r_raw[7];
        end
    end

endmodule

// ----- sv/rhc_emit.sv -----
// ----------------------------------------------------------------------------
// rhc_emit
// Holds one item's corners, classifies the overlap and emits its pieces,
// one per cycle while the result side is ready, through the result register.
// ----------------------------------------------------------------------------
module rhc_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rhc_pkg::t_corners    i_corners,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_piece_x0,
    output logic signed [31:0]   o_piece_y0,
    output logic signed [31:0]   o_piece_x1,
    output logic signed [31:0]   o_piece_y1,
    output logic                 o_found,
    output logic                 o_piece_valid,
    output logic                 o_piece_last
);
    import rhc_pkg::*;

    logic           r_vld;
    t_corners       r_c;
    logic [2:0]     r_k;
    logic           r_out_vld;
    logic [31:0]    r_x0, r_y0, r_x1, r_y1;
    logic           r_found, r_pvalid, r_last;

    logic           out_free, emit, no_cut, last;
    logic [3:0]     sel, cnt;
    logic [7:0]     ent;
    logic [31:0]    n_x0, n_y0, n_x1, n_y1;
    logic           n_found, n_pvalid;

    always_comb begin
        no_cut = (r_c.xs[SEL_R0] == r_c.xs[SEL_R1]) || (r_c.ys[SEL_R0] == r_c.ys[SEL_R1])
              || (r_c.xs[SEL_H0] == r_c.xs[SEL_H1]) || (r_c.ys[SEL_H0] == r_c.ys[SEL_H1])
              || ($signed(r_c.xs[SEL_H1]) <= $signed(r_c.xs[SEL_R0]))
              || ($signed(r_c.xs[SEL_H0]) >= $signed(r_c.xs[SEL_R1]))
              || ($signed(r_c.ys[SEL_H1]) <= $signed(r_c.ys[SEL_R0]))
              || ($signed(r_c.ys[SEL_H0]) >= $signed(r_c.ys[SEL_R1]));
        sel[0] = $signed(r_c.xs[SEL_H0]) <= $signed(r_c.xs[SEL_R0]);
        sel[1] = $signed(r_c.xs[SEL_H1]) >= $signed(r_c.xs[SEL_R1]);
        sel[2] = $signed(r_c.ys[SEL_H0]) <= $signed(r_c.ys[SEL_R0]);
        sel[3] = $signed(r_c.ys[SEL_H1]) >= $signed(r_c.ys[SEL_R1]);
        cnt = PIECE_COUNT[sel];
        ent = PIECE_TABLE[sel][r_k];
        if (no_cut) begin
            n_x0     = r_c.xs[SEL_R0];
            n_y0     = r_c.ys[SEL_R0];
            n_x1     = r_c.xs[SEL_R1];
            n_y1     = r_c.ys[SEL_R1];
            n_found  = 1'b0;
            n_pvalid = 1'b1;
            last     = 1'b1;
        end else if (cnt == 4'd0) begin
            n_x0     = '0;
            n_y0     = '0;
            n_x1     = '0;
            n_y1     = '0;
            n_found  = 1'b1;
            n_pvalid = 1'b0;
            last     = 1'b1;
        end else begin
            n_x0     = r_c.xs[ent[1:0]];
            n_x1     = r_c.xs[ent[3:2]];
            n_y0     = r_c.ys[ent[5:4]];
            n_y1     = r_c.ys[ent[7:6]];
            n_found  = 1'b1;
            n_pvalid = 1'b1;
            last     = ({1'b0, r_k} == cnt - 4'd1);
        end
    end

    assign out_free = !r_out_vld || i_ready;
    assign emit     = r_vld && out_free;
    assign o_ready  = !r_vld || (emit && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_vld <= i_valid;
            end
            if (emit) begin
                r_k <= last ? 3'd0 : r_k + 3'd1;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (o_ready && i_valid) begin
            r_c <= i_corners;
        end
        if (emit) begin
            r_x0     <= n_x0;
            r_y0     <= n_y0;
            r_x1     <= n_x1;
            r_y1     <= n_y1;
            r_found  <= n_found;
            r_pvalid <= n_pvalid;
            r_last   <= last;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_piece_x0    = r_x0;
    assign o_piece_y0    = r_y0;
    assign o_piece_x1    = r_x1;
    assign o_piece_y1    = r_y1;
    assign o_found       = r_found;
    assign o_piece_valid = r_pvalid;
    assign o_piece_last  = r_last;

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !no_cut && cnt != 4'd0) |-> ({1'b0, r_k} < cnt))
        else $error("piece index past piece count");

    a_k_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld |-> (r_k == 3'd0))
        else $error("piece index not rewound between items");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !last) |=> (r_vld && r_k == $past(r_k) + 3'd1))
        else $error("item dropped before its last piece");

    a_covered_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_pvalid) |-> (r_found && r_last && r_x0 == '0 && r_y1 == '0))
        else $error("fully covered result malformed");

    a_nocut_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_found) |-> (r_last && r_pvalid))
        else $error("uncut result not a single piece");

endmodule

// ----- sv/rectangle_hole_cut.sv -----
// ----------------------------------------------------------------------------
// rectangle_hole_cut
// Cuts an axis-aligned hole out of a rectangle and returns the pieces left.
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_ready  i_req_type, i_rect_*, i_hole_*
//   result    out        o_valid / i_ready  o_piece_*, o_found
//
// An item enters the input register, is converted to corners, then emits 1 to 8
// results through the result register, one per cycle while the result side
// accepts them; the next item is taken in as its last result is emitted.
// Reset clears the valid flags and the piece index.
// A stalled result side holds the piece in the result register; the item being
// cut and one more item in the input register wait behind it.
// ----------------------------------------------------------------------------
module rectangle_hole_cut (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_req_type,
    input  logic signed [31:0]   i_rect_ax,
    input  logic signed [31:0]   i_rect_ay,
    input  logic signed [31:0]   i_rect_bx,
    input  logic signed [31:0]   i_rect_by,
    input  logic signed [31:0]   i_hole_ax,
    input  logic signed [31:0]   i_hole_ay,
    input  logic signed [31:0]   i_hole_bx,
    input  logic signed [31:0]   i_hole_by,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [31:0]   o_piece_x0,
    output logic signed [31:0]   o_piece_y0,
    output logic signed [31:0]   o_piece_x1,
    output logic signed [31:0]   o_piece_y1,
    output logic                 o_found,
    output logic                 o_piece_valid,
    output logic                 o_piece_last
);
    import rhc_pkg::*;

    logic       c_valid;
    logic       c_ready;
    t_corners   corners;

    rhc_corners u_corners (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_rect_ax  (i_rect_ax),
        .i_rect_ay  (i_rect_ay),
        .i_rect_bx  (i_rect_bx),
        .i_rect_by  (i_rect_by),
        .i_hole_ax  (i_hole_ax),
        .i_hole_ay  (i_hole_ay),
        .i_hole_bx  (i_hole_bx),
        .i_hole_by  (i_hole_by),
        .o_valid    (c_valid),
        .i_ready    (c_ready),
        .o_corners  (corners)
    );

    rhc_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (c_valid),
        .o_ready       (c_ready),
        .i_corners     (corners),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_piece_x0    (o_piece_x0),
        .o_piece_y0    (o_piece_y0),
        .o_piece_x1    (o_piece_x1),
        .o_piece_y1    (o_piece_y1),
        .o_found       (o_found),
        .o_piece_valid (o_piece_valid),
        .o_piece_last  (o_piece_last)
    );

endmodule

// ----- tb/tb_rectangle_hole_cut.sv -----
// ----------------------------------------------------------------------------
// tb_rectangle_hole_cut
// Self-checking testbench for the rectangle hole cut block. A driver feeds
// requests from a queue, each accepted request is cut in a local model that
// queues the expected pieces, and a monitor compares every piece that leaves
// the block. Directed cases cover every edge-flag layout and the no-cut,
// full-cover, reversed and center-form cases; random requests follow. Both
// sides stall at random, except during a calm stretch of requests.
// ----------------------------------------------------------------------------
module tb_rectangle_hole_cut;
    timeunit 1ns;
    timeprecision 1ps;

    import rhc_pkg::*;

    localparam int N_RANDOM   = 350;
    localparam int STALL_PCT  = 15;
    localparam int CALM_LO    = 120;
    localparam int CALM_HI    = 200;
    localparam int WDOG_LIMIT = 2000;
    localparam int END_WAIT   = 20;

    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;

    // pieces per edge-flag code {ey, sy, ex, sx}
    localparam logic [3:0] CUT_COUNT [16] = '{
        4'd8, 4'd3, 4'd3, 4'd2, 4'd3, 4'd2, 4'd2, 4'd1,
        4'd3, 4'd2, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1, 4'd0
    };

    // corner selects per piece: [1:0] x0, [3:2] x1, [5:4] y0, [7:6] y1
    localparam logic [7:0] CUT_LAYOUT [16][8] = '{
        '{8'h88, 8'h8E, 8'h87, 8'hE8, 8'hE7, 8'h78, 8'h7E, 8'h77},
        '{8'h84, 8'hE7, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h84, 8'hE8, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h84, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h7E, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hC7, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hC8, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h8E, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h84, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h84, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h84, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h47, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic   center;
        t_coord rax;
        t_coord ray;
        t_coord rbx;
        t_coord rby;
        t_coord hax;
        t_coord hay;
        t_coord hbx;
        t_coord hby;
        logic   drain;
    } t_cut_req;

    typedef struct packed {
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
        logic   found;
        logic   pvalid;
        logic   last;
    } t_piece;

    logic   i_clk         = 1'b0;
    logic   i_rst_n       = 1'b0;
    logic   i_valid       = 1'b0;
    logic   o_ready;
    logic   i_req_type    = 1'b0;
    t_coord i_rect_ax     = '0;
    t_coord i_rect_ay     = '0;
    t_coord i_rect_bx     = '0;
    t_coord i_rect_by     = '0;
    t_coord i_hole_ax     = '0;
    t_coord i_hole_ay     = '0;
    t_coord i_hole_bx     = '0;
    t_coord i_hole_by     = '0;
    logic   o_valid;
    logic   i_ready       = 1'b0;
    t_coord o_piece_x0;
    t_coord o_piece_y0;
    t_coord o_piece_x1;
    t_coord o_piece_y1;
    logic   o_found;
    logic   o_piece_valid;
    logic   o_piece_last;

    t_cut_req pending [$];
    t_piece   pieces_due [$];
    t_cut_req on_bus;
    int       n_total     = 0;
    int       n_sent      = 0;
    int       n_pieces    = 0;
    int       n_bad       = 0;
    int       idle_cycles = 0;
    logic     calm;

    assign calm = (n_sent >= CALM_LO) && (n_sent < CALM_HI);

    rectangle_hole_cut u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_rect_ax     (i_rect_ax),
        .i_rect_ay     (i_rect_ay),
        .i_rect_bx     (i_rect_bx),
        .i_rect_by     (i_rect_by),
        .i_hole_ax     (i_hole_ax),
        .i_hole_ay     (i_hole_ay),
        .i_hole_bx     (i_hole_bx),
        .i_hole_by     (i_hole_by),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_piece_x0    (o_piece_x0),
        .o_piece_y0    (o_piece_y0),
        .o_piece_x1    (o_piece_x1),
        .o_piece_y1    (o_piece_y1),
        .o_found       (o_found),
        .o_piece_valid (o_piece_valid),
        .o_piece_last  (o_piece_last)
    );

    task automatic note_mismatch(input string msg);
        n_bad++;
        $display("mismatch: %s", msg);
    endtask

    function automatic string piece_text(input t_piece p);
        return $sformatf("%0d %0d %0d %0d f%0b v%0b l%0b",
                         p.x0, p.y0, p.x1, p.y1, p.found, p.pvalid, p.last);
    endfunction

    // center/size to low/high corner, wrapping at 32 bits
    task automatic to_corners(input t_coord c, input t_coord s,
                              output t_coord lo, output t_coord hi);
        t_coord half;
        half = s / 32'sd2;
        lo   = c - half;
        hi   = c + s - half;
    endtask

    task automatic cut_hole(input t_cut_req r);
        t_coord   xs [4];
        t_coord   ys [4];
        logic [3:0] code;
        logic [7:0] sel;
        int       n;
        t_piece   p;
        if (r.center) begin
            to_corners(r.rax, r.rbx, xs[SEL_R0], xs[SEL_R1]);
            to_corners(r.ray, r.rby, ys[SEL_R0], ys[SEL_R1]);
            to_corners(r.hax, r.hbx, xs[SEL_H0], xs[SEL_H1]);
            to_corners(r.hay, r.hby, ys[SEL_H0], ys[SEL_H1]);
        end else begin
            xs[SEL_R0] = r.rax; ys[SEL_R0] = r.ray;
            xs[SEL_R1] = r.rbx; ys[SEL_R1] = r.rby;
            xs[SEL_H0] = r.hax; ys[SEL_H0] = r.hay;
            xs[SEL_H1] = r.hbx; ys[SEL_H1] = r.hby;
        end
        if (xs[SEL_R0] == xs[SEL_R1] || ys[SEL_R0] == ys[SEL_R1]
                || xs[SEL_H0] == xs[SEL_H1] || ys[SEL_H0] == ys[SEL_H1]
                || xs[SEL_H1] <= xs[SEL_R0] || xs[SEL_H0] >= xs[SEL_R1]
                || ys[SEL_H1] <= ys[SEL_R0] || ys[SEL_H0] >= ys[SEL_R1]) begin
            p = '{xs[SEL_R0], ys[SEL_R0], xs[SEL_R1], ys[SEL_R1], 1'b0, 1'b1, 1'b1};
            pieces_due.push_back(p);
            return;
        end
        code = {ys[SEL_H1] >= ys[SEL_R1], ys[SEL_H0] <= ys[SEL_R0],
                xs[SEL_H1] >= xs[SEL_R1], xs[SEL_H0] <= xs[SEL_R0]};
        n = CUT_COUNT[code];
        if (n == 0) begin
            p = '{'0, '0, '0, '0, 1'b1, 1'b0, 1'b1};
            pieces_due.push_back(p);
            return;
        end
        for (int k = 0; k < n; k++) begin
            sel = CUT_LAYOUT[code][k];
            p = '{xs[sel[1:0]], ys[sel[5:4]], xs[sel[3:2]], ys[sel[7:6]],
                  1'b1, 1'b1, k == n - 1};
            pieces_due.push_back(p);
        end
    endtask

    task automatic add_req(input logic center, input t_coord rax, input t_coord ray,
                           input t_coord rbx, input t_coord rby, input t_coord hax,
                           input t_coord hay, input t_coord hbx, input t_coord hby,
                           input logic drain);
        t_cut_req r;
        r = '{center, rax, ray, rbx, rby, hax, hay, hbx, hby, drain};
        pending.push_back(r);
    endtask

    function automatic t_coord pick_base();
        if ($urandom_range(9) < 7)
            return t_coord'($urandom_range(2000)) - 32'sd1000;
        return t_coord'($urandom);
    endfunction

    function automatic t_coord pick_span();
        case ($urandom_range(9))
            0:       return 32'sd1;
            1, 2, 3: return t_coord'($urandom_range(20, 1));
            9:       return t_coord'($urandom);
            default: return t_coord'($urandom_range(2000, 1));
        endcase
    endfunction

    // a hole edge beyond, on or between the rectangle edges
    function automatic t_coord edge_near(input t_coord lo, input t_coord hi);
        logic [COORD_W-1:0] span;
        span = hi - lo;
        case ($urandom_range(4))
            0:       return lo - t_coord'($urandom_range(50, 1));
            1:       return lo;
            2:       return (span > 1) ? lo + 1 + t_coord'($urandom % (span - 1)) : lo;
            3:       return hi;
            default: return hi + t_coord'($urandom_range(50, 1));
        endcase
    endfunction

    task automatic swap_coords(inout t_coord a, inout t_coord b);
        t_coord t;
        t = a;
        a = b;
        b = t;
    endtask

    task automatic corner_to_center(inout t_coord a, inout t_coord b);
        t_coord s;
        s = b - a;
        a = a + s / 32'sd2;
        b = s;
    endtask

    task automatic add_shaped(input logic drain);
        t_coord rx0, ry0, rx1, ry1, hx0, hy0, hx1, hy1;
        logic   center;
        rx0 = pick_base();
        ry0 = pick_base();
        rx1 = rx0 + pick_span();
        ry1 = ry0 + pick_span();
        hx0 = edge_near(rx0, rx1);
        hx1 = edge_near(rx0, rx1);
        hy0 = edge_near(ry0, ry1);
        hy1 = edge_near(ry0, ry1);
        if (hx0 > hx1 && $urandom_range(9) != 0)
            swap_coords(hx0, hx1);
        if (hy0 > hy1 && $urandom_range(9) != 0)
            swap_coords(hy0, hy1);
        if ($urandom_range(19) == 0)
            swap_coords(rx0, rx1);
        if ($urandom_range(19) == 0)
            swap_coords(ry0, ry1);
        center = $urandom_range(1);
        if (center) begin
            corner_to_center(rx0, rx1);
            corner_to_center(ry0, ry1);
            corner_to_center(hx0, hx1);
            corner_to_center(hy0, hy1);
        end
        add_req(center, rx0, ry0, rx1, ry1, hx0, hy0, hx1, hy1, drain);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : stimulus
        logic drain;
        // no cut: empty rect, empty hole, touching on the right and below
        add_req(1'b0, 0, 0, 0, 100, 10, 10, 20, 20, 1'b0);
        add_req(1'b0, 0, 0, 100, 100, 10, 50, 20, 50, 1'b0);
        add_req(1'b0, 0, 0, 100, 100, 100, 10, 150, 20, 1'b0);
        add_req(1'b0, 0, 0, 100, 100, 10, -50, 20, 0, 1'b0);
        // every edge-flag layout, including the hole covering all
        for (int code = 0; code < 16; code++)
            add_req(1'b0, -1000, -1000, 1000, 1000,
                    code[0] ? -1000 : -500, code[2] ? -1500 : -500,
                    code[1] ? 1500 : 500, code[3] ? 1000 : 500, 1'b0);
        add_req(1'b0, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, 0, 0, C_MAX, 1'b0);
        // reversed hole corners
        add_req(1'b0, 0, 0, 100, 100, 80, 80, 20, 20, 1'b0);
        // center form: odd and negative sizes, wrap at extremes, full cover
        add_req(1'b1, 0, 0, 101, -7, 10, 0, 3, 5, 1'b0);
        add_req(1'b1, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, 1'b0);
        add_req(1'b1, 0, 0, 10, 10, 0, 0, 20, 20, 1'b0);

        for (int i = 0; i < N_RANDOM; i++) begin
            drain = (i == N_RANDOM / 2) || ($urandom_range(49) == 0);
            if ($urandom_range(99) < 15)
                add_req($urandom_range(1), $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, drain);
            else
                add_shaped(drain);
        end
        n_total = pending.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != n_total)
            @(posedge i_clk);
        while (pieces_due.size() != 0)
            @(posedge i_clk);
        repeat (END_WAIT) @(posedge i_clk);

        if (n_bad == 0)
            $display("** rectangle_hole_cut: PASSED **");
        else
            $display("** rectangle_hole_cut: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin : drive
        logic go;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                cut_hole(on_bus);
                n_sent++;
            end
            if (!i_valid || o_ready) begin
                go = pending.size() != 0 && (calm || $urandom_range(99) >= STALL_PCT);
                // hold off until every piece of earlier items has left
                if (go && pending[0].drain && pieces_due.size() != 0)
                    go = 1'b0;
                if (go) begin
                    on_bus = pending.pop_front();
                    i_req_type <= on_bus.center;
                    i_rect_ax  <= on_bus.rax;
                    i_rect_ay  <= on_bus.ray;
                    i_rect_bx  <= on_bus.rbx;
                    i_rect_by  <= on_bus.rby;
                    i_hole_ax  <= on_bus.hax;
                    i_hole_ay  <= on_bus.hay;
                    i_hole_bx  <= on_bus.hbx;
                    i_hole_by  <= on_bus.hby;
                end
                i_valid <= go;
            end
        end
    end

    always @(posedge i_clk) begin : collect
        t_piece got;
        t_piece want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = '{o_piece_x0, o_piece_y0, o_piece_x1, o_piece_y1,
                        o_found, o_piece_valid, o_piece_last};
                if (pieces_due.size() == 0) begin
                    note_mismatch($sformatf("piece %0d not expected: %s",
                        n_pieces, piece_text(got)));
                end else begin
                    want = pieces_due.pop_front();
                    if (got !== want)
                        note_mismatch($sformatf("piece %0d got %s want %s",
                            n_pieces, piece_text(got), piece_text(want)));
                end
                n_pieces++;
            end
            i_ready <= calm || ($urandom_range(99) >= STALL_PCT);
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("** rectangle_hole_cut: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ----- rectangle_hole_cut.f -----
sv/rhc_pkg.sv
sv/rhc_corners.sv
sv/rhc_emit.sv
sv/rectangle_hole_cut.sv
tb/tb_rectangle_hole_cut.sv
